### rtl/kpdb_pkg.sv
// Package for the keypad per-key debouncer.
// Holds the field types and fixed widths shared by the evaluation lanes and the top level.
// No dependencies.
package kpdb_pkg;

  localparam int KEY_FIELD_W = 16;
  localparam int TIME_W      = 32;
  localparam int DELAY_W     = 16;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd3;

  typedef logic [KEY_FIELD_W-1:0] key_vec_t;
  typedef logic [TIME_W-1:0]      stamp_t;
  typedef logic [DELAY_W-1:0]     delay_t;

  localparam key_vec_t KEYS_RELEASED = '1;

  typedef struct packed {
    key_vec_t raw_keys;
    stamp_t   time_ms;
  } scan_t;

  typedef struct packed {
    key_vec_t pressed_mask;
    logic     changed;
  } result_t;

endpackage

### rtl/kpdb_key_eval.sv
// Per-key evaluation lanes of the keypad debouncer: restamp, elapsed-time check, level update.
// Purely combinational; one independent lane per handled key.
// Depends on kpdb_pkg.
module kpdb_key_eval #(
  parameter int ACTIVE_KEYS = 16
) (
  input  kpdb_pkg::scan_t    scan,
  input  kpdb_pkg::key_vec_t prev_raw,
  input  kpdb_pkg::key_vec_t stable,
  input  kpdb_pkg::delay_t   delay,
  input  kpdb_pkg::stamp_t   stamps     [ACTIVE_KEYS],
  output kpdb_pkg::stamp_t   stamps_nxt [ACTIVE_KEYS],
  output kpdb_pkg::key_vec_t stable_nxt,
  output logic               changed
);

  kpdb_pkg::key_vec_t flip;

  for (genvar i = 0; i < kpdb_pkg::KEY_FIELD_W; i++) begin : g_lane
    if (i < ACTIVE_KEYS) begin : g_active
      logic             raw_moved;
      kpdb_pkg::stamp_t elapsed;

      assign raw_moved     = prev_raw[i] ^ scan.raw_keys[i];
      assign elapsed       = scan.time_ms - stamps[i];
      assign stamps_nxt[i] = raw_moved ? scan.time_ms : stamps[i];
      assign flip[i]       = !raw_moved && (stable[i] != scan.raw_keys[i]) &&
                             (elapsed > {{(kpdb_pkg::TIME_W-kpdb_pkg::DELAY_W){1'b0}}, delay});
      assign stable_nxt[i] = flip[i] ? scan.raw_keys[i] : stable[i];
    end else begin : g_idle
      assign flip[i]       = 1'b0;
      assign stable_nxt[i] = 1'b1;
    end
  end

  assign changed = |flip;

endmodule

### rtl/keypad_per_key_debouncer_core.sv
// Top level of the keypad per-key debouncer: input register, key state, result register, config.
// Depends on kpdb_pkg and kpdb_key_eval.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, in_raw_keys, in_time_ms | into core
//   out     | out_valid, out_stall, out_pressed_mask, out_changed | out of core
//   cfg     | cfg_valid, cfg_ready, cfg_data (debounce delay) | into core
//
// One scan word per cycle unless out is stalled; the result register follows the input register.
// The input register feeds the key lanes, which update the key state and load
// the result register in the same cycle, so back-to-back scans see fresh state.
// Reset (synchronous, rst_n low): delay 3, all keys released, all stamps zero.
// A stalled result holds the lane stage; in_stall rises only when the input register is also full.
module keypad_per_key_debouncer_core #(
  parameter int KEY_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  kpdb_pkg::key_vec_t  in_raw_keys,
  input  kpdb_pkg::stamp_t    in_time_ms,

  output logic                out_valid,
  input  logic                out_stall,
  output kpdb_pkg::key_vec_t  out_pressed_mask,
  output logic                out_changed,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  kpdb_pkg::delay_t    cfg_data
);

  localparam int ACTIVE_KEYS = (KEY_COUNT > kpdb_pkg::KEY_FIELD_W) ?
                               kpdb_pkg::KEY_FIELD_W : KEY_COUNT;

  kpdb_pkg::scan_t    scan_r;
  logic               scan_valid_r;
  kpdb_pkg::key_vec_t prev_raw_r;
  kpdb_pkg::key_vec_t stable_r;
  kpdb_pkg::delay_t   delay_r;
  kpdb_pkg::stamp_t   stamps_r   [ACTIVE_KEYS];
  kpdb_pkg::stamp_t   stamps_nxt [ACTIVE_KEYS];
  kpdb_pkg::key_vec_t stable_nxt;
  logic               changed_nxt;
  kpdb_pkg::result_t  result_r;
  logic               result_valid_r;

  logic               in_take;
  logic               advance;

  assign advance   = scan_valid_r && (!result_valid_r || !out_stall);
  assign in_stall  = scan_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  kpdb_key_eval #(
    .ACTIVE_KEYS (ACTIVE_KEYS)
  ) u_key_eval (
    .scan       (scan_r),
    .prev_raw   (prev_raw_r),
    .stable     (stable_r),
    .delay      (delay_r),
    .stamps     (stamps_r),
    .stamps_nxt (stamps_nxt),
    .stable_nxt (stable_nxt),
    .changed    (changed_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_valid_r   <= 1'b0;
      result_valid_r <= 1'b0;
      prev_raw_r     <= kpdb_pkg::KEYS_RELEASED;
      stable_r       <= kpdb_pkg::KEYS_RELEASED;
      delay_r        <= kpdb_pkg::DELAY_RESET;
      for (int i = 0; i < ACTIVE_KEYS; i++) begin
        stamps_r[i] <= '0;
      end
    end else begin
      if (in_take) begin
        scan_valid_r <= 1'b1;
      end else if (advance) begin
        scan_valid_r <= 1'b0;
      end
      if (advance) begin
        result_valid_r <= 1'b1;
      end else if (!out_stall) begin
        result_valid_r <= 1'b0;
      end
      if (advance) begin
        prev_raw_r <= scan_r.raw_keys;
        stable_r   <= stable_nxt;
        stamps_r   <= stamps_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        delay_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      scan_r.raw_keys <= in_raw_keys;
      scan_r.time_ms  <= in_time_ms;
    end
    if (advance) begin
      result_r.pressed_mask <= ~stable_nxt;
      result_r.changed      <= changed_nxt;
    end
  end

  assign out_valid        = result_valid_r;
  assign out_pressed_mask = result_r.pressed_mask;
  assign out_changed      = result_r.changed;

endmodule
